FILE: hdl/cps_pkg.sv
`default_nettype none

package cps_pkg;

  localparam int CPS_COUNT_BITS = 16;
  localparam int DEN_BITS       = 16;
  localparam int QUOT_BITS      = 17;
  localparam int FRAC_SHIFT     = 16;
  localparam int ANGLE_BITS     = 16;

  localparam logic [DEN_BITS-1:0]   SAMPLE_TOTAL_RESET = 16'd360;
  localparam logic [DEN_BITS-1:0]   DEN_ONE            = 16'd1;
  localparam logic [ANGLE_BITS-1:0] ANGLE_SCALE        = 16'd46080;
  localparam logic [QUOT_BITS-1:0]  ANGLE_MAX          = 17'd46080;
  localparam logic [QUOT_BITS-1:0]  FRAC_MAX           = 17'd65536;
  // 720*run >= total is the same test as floor(46080*run/total) >= 64
  localparam logic [QUOT_BITS-1:0]  SEG_MIN_ANGLE      = 17'd64;

  // dividend sources
  localparam logic [1:0] SRC_OLD_RUN = 2'd0;
  localparam logic [1:0] SRC_CUR_RUN = 2'd1;
  localparam logic [1:0] SRC_FRAC    = 2'd2;

  // which count of a leg
  localparam logic [1:0] WHICH_CLAMP = 2'd0;
  localparam logic [1:0] WHICH_HIGH  = 2'd1;
  localparam logic [1:0] WHICH_LOW   = 2'd2;

  localparam logic [1:0] LEG_FIRST = 2'd0;
  localparam logic [1:0] LEG_LAST  = 2'd2;
  localparam logic [1:0] LEG_NONE  = 2'd3;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  localparam logic [1:0] PBITS_NONE = 2'b00;
  localparam logic [1:0] PBITS_HIGH = 2'b01;

  localparam logic [1:0] EFF_ZERO = 2'b00;
  localparam logic [1:0] EFF_HIGH = 2'b01;
  localparam logic [1:0] EFF_LOW  = 2'b11;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       div_start;
    logic       capture;
    logic       out_load;
    logic       out_kind;
    logic       out_final;
    logic       clear;
    logic [1:0] src;
    logic [1:0] leg;
    logic [1:0] which;
  } cps_cmd_t;

  typedef struct packed {
    logic pend_old;
    logic pend_last;
    logic cur_nonzero;
    logic div_done;
    logic seg_ok;
  } cps_stat_t;

endpackage

`default_nettype wire

FILE: hdl/cps_in_if.sv
`default_nettype none

interface cps_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        clamp_leg_in;
  logic signed [1:0] clamp_polarity_in;
  logic              end_of_set;

  modport source (
    output valid, clamp_leg_in, clamp_polarity_in, end_of_set,
    input  ready
  );
  modport sink (
    input  valid, clamp_leg_in, clamp_polarity_in, end_of_set,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/cps_out_if.sv
`default_nettype none

interface cps_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [1:0]  summary_leg;
  logic [16:0] clamp_share;
  logic [16:0] high_fraction;
  logic [16:0] low_fraction;
  logic [15:0] segment_angle;
  logic        final_result;

  modport source (
    output valid, result_kind, summary_leg, clamp_share, high_fraction,
           low_fraction, segment_angle, final_result,
    input  ready
  );
  modport sink (
    input  valid, result_kind, summary_leg, clamp_share, high_fraction,
           low_fraction, segment_angle, final_result,
    output ready
  );
endinterface

`default_nettype wire

FILE: hdl/cps_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is QUOT_BITS
// wide; a dividend whose quotient does not fit reads as all ones.
module cps_div import cps_pkg::*; #(
  parameter int DIVIDEND_BITS = CPS_COUNT_BITS + FRAC_SHIFT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DEN_BITS-1:0]      divisor,
  output logic                     done,
  output logic [QUOT_BITS-1:0]     quotient
);

  localparam int HI_BITS   = DIVIDEND_BITS - QUOT_BITS;
  localparam int CMP_BITS  = (HI_BITS > DEN_BITS) ? HI_BITS : DEN_BITS;
  localparam int STEP_BITS = $clog2(QUOT_BITS + 1);

  logic [DEN_BITS-1:0]  rem;
  logic [DEN_BITS-1:0]  den;
  logic [QUOT_BITS-1:0] low;
  logic [QUOT_BITS-1:0] quo;
  logic                 ovf;
  logic [STEP_BITS-1:0] steps;

  logic [CMP_BITS-1:0]  hi_ext;
  logic [CMP_BITS-1:0]  den_ext;
  logic [DEN_BITS:0]    trial;
  logic [DEN_BITS:0]    diff;
  logic                 fits;

  assign hi_ext  = CMP_BITS'(dividend[DIVIDEND_BITS-1:QUOT_BITS]);
  assign den_ext = CMP_BITS'(divisor);
  assign trial   = {rem, low[QUOT_BITS-1]};
  assign fits    = trial >= {1'b0, den};
  assign diff    = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // high part below the divisor unless the quotient overflows
        rem   <= hi_ext[DEN_BITS-1:0];
        low   <= dividend[QUOT_BITS-1:0];
        den   <= divisor;
        ovf   <= hi_ext >= den_ext;
        quo   <= '0;
        steps <= STEP_BITS'(QUOT_BITS);
      end else if (steps != '0) begin
        rem   <= fits ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
        low   <= {low[QUOT_BITS-2:0], 1'b0};
        quo   <= {quo[QUOT_BITS-2:0], fits};
        steps <= steps - STEP_BITS'(1);
        done  <= steps == STEP_BITS'(1);
      end
    end
  end

  assign quotient = ovf ? '1 : quo;

endmodule

`default_nettype wire

FILE: hdl/cps_datapath.sv
`default_nettype none

module cps_datapath import cps_pkg::*; #(
  parameter int COUNT_BITS = CPS_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [DEN_BITS-1:0]   cfg_write_data,
  input  logic [1:0]            clamp_leg_in,
  input  logic signed [1:0]     clamp_polarity_in,
  input  logic                  end_of_set,
  input  cps_cmd_t              cmd,
  output cps_stat_t             stat,
  output logic                  result_kind,
  output logic [1:0]            summary_leg,
  output logic [QUOT_BITS-1:0]  clamp_share,
  output logic [QUOT_BITS-1:0]  high_fraction,
  output logic [QUOT_BITS-1:0]  low_fraction,
  output logic [ANGLE_BITS-1:0] segment_angle,
  output logic                  final_result
);

  localparam int DIV_W = COUNT_BITS + FRAC_SHIFT;

  logic [DEN_BITS-1:0]   sample_total;
  logic                  first_pending;
  logic [1:0]            previous_polarity;
  logic [COUNT_BITS-1:0] run_count;
  logic [COUNT_BITS-1:0] seg_run;
  logic [COUNT_BITS-1:0] leg_clamp_count [3];
  logic [COUNT_BITS-1:0] leg_high_count [3];
  logic [COUNT_BITS-1:0] leg_low_count [3];
  logic                  pend_old;
  logic                  pend_last;

  logic [DIV_W-1:0]      div_n;
  logic [DIV_W-1:0]      div_n_next;
  logic [DEN_BITS-1:0]   den;
  logic                  div_done;
  logic [QUOT_BITS-1:0]  quot;

  logic [ANGLE_BITS-1:0] seg_ang;
  logic                  seg_ok;
  logic [QUOT_BITS-1:0]  frac_clamp;
  logic [QUOT_BITS-1:0]  frac_high;
  logic [QUOT_BITS-1:0]  frac_low;
  logic [QUOT_BITS-1:0]  quot_frac;
  logic [QUOT_BITS-1:0]  quot_ang;

  logic [1:0]            pbits;
  logic [1:0]            eff;
  logic [COUNT_BITS-1:0] run_sel;
  logic [COUNT_BITS-1:0] count_sel;

  assign pbits = clamp_polarity_in;

  always_comb begin
    if (clamp_leg_in == LEG_NONE) begin
      eff = EFF_ZERO;
    end else begin
      case (pbits)
        PBITS_NONE: eff = EFF_ZERO;
        PBITS_HIGH: eff = EFF_HIGH;
        default:    eff = EFF_LOW;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_total <= SAMPLE_TOTAL_RESET;
    end else if (cfg_write_en) begin
      sample_total <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      first_pending     <= 1'b1;
      previous_polarity <= EFF_ZERO;
      run_count         <= '0;
      pend_old          <= 1'b0;
      pend_last         <= 1'b0;
    end else if (cmd.accept) begin
      pend_last <= end_of_set;
      seg_run   <= run_count;
      pend_old  <= !first_pending && (eff != previous_polarity)
                   && (previous_polarity != EFF_ZERO);
      if (first_pending) begin
        first_pending     <= 1'b0;
        previous_polarity <= eff;
        run_count         <= COUNT_BITS'(1);
      end else if (eff == previous_polarity) begin
        run_count <= (run_count == '1) ? run_count : run_count + 1'b1;
      end else begin
        previous_polarity <= eff;
        run_count         <= COUNT_BITS'(1);
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_leg
    always_ff @(posedge clk) begin
      if (rst || cmd.clear) begin
        leg_clamp_count[j] <= '0;
        leg_high_count[j]  <= '0;
        leg_low_count[j]   <= '0;
      end else if (cmd.accept && clamp_leg_in == 2'(j)) begin
        if (leg_clamp_count[j] != '1) begin
          leg_clamp_count[j] <= leg_clamp_count[j] + 1'b1;
        end
        if (pbits == PBITS_HIGH) begin
          if (leg_high_count[j] != '1) begin
            leg_high_count[j] <= leg_high_count[j] + 1'b1;
          end
        end else if (pbits != PBITS_NONE) begin
          if (leg_low_count[j] != '1) begin
            leg_low_count[j] <= leg_low_count[j] + 1'b1;
          end
        end
      end
    end
  end

  assign run_sel = (cmd.src == SRC_OLD_RUN) ? seg_run : run_count;

  always_comb begin
    unique case (cmd.which)
      WHICH_CLAMP: count_sel = leg_clamp_count[cmd.leg];
      WHICH_HIGH:  count_sel = leg_high_count[cmd.leg];
      default:     count_sel = leg_low_count[cmd.leg];
    endcase
  end

  always_comb begin
    unique case (cmd.src)
      SRC_FRAC: div_n_next = {count_sel, FRAC_SHIFT'(0)};
      default:  div_n_next = DIV_W'(run_sel) * DIV_W'(ANGLE_SCALE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      div_n <= div_n_next;
    end
  end

  assign den = (sample_total == '0) ? DEN_ONE : sample_total;

  cps_div #(
    .DIVIDEND_BITS(DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  assign quot_frac = (quot > FRAC_MAX) ? FRAC_MAX : quot;
  assign quot_ang  = (quot > ANGLE_MAX) ? ANGLE_MAX : quot;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      if (cmd.src == SRC_FRAC) begin
        unique case (cmd.which)
          WHICH_CLAMP: frac_clamp <= quot_frac;
          WHICH_HIGH:  frac_high  <= quot_frac;
          default:     frac_low   <= quot_frac;
        endcase
      end else begin
        seg_ang <= quot_ang[ANGLE_BITS-1:0];
        seg_ok  <= quot >= SEG_MIN_ANGLE;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_kind  <= cmd.out_kind;
      final_result <= cmd.out_final;
      if (cmd.out_kind == KIND_SUMMARY) begin
        summary_leg    <= cmd.leg;
        clamp_share    <= frac_clamp;
        high_fraction  <= frac_high;
        low_fraction   <= frac_low;
        segment_angle  <= '0;
      end else begin
        summary_leg    <= '0;
        clamp_share    <= '0;
        high_fraction  <= '0;
        low_fraction   <= '0;
        segment_angle  <= seg_ang;
      end
    end
  end

  assign stat.pend_old    = pend_old;
  assign stat.pend_last   = pend_last;
  assign stat.cur_nonzero = previous_polarity != EFF_ZERO;
  assign stat.div_done    = div_done;
  assign stat.seg_ok      = seg_ok;

endmodule

`default_nettype wire

FILE: hdl/cps_controller.sv
`default_nettype none

module cps_controller import cps_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  cps_stat_t stat,
  output cps_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE        = 4'd0;
  localparam logic [3:0] S_CHECK_OLD   = 4'd1;
  localparam logic [3:0] S_CHECK_FLUSH = 4'd2;
  localparam logic [3:0] S_LOAD        = 4'd3;
  localparam logic [3:0] S_START       = 4'd4;
  localparam logic [3:0] S_WAIT        = 4'd5;
  localparam logic [3:0] S_AFTER_RUN   = 4'd6;
  localparam logic [3:0] S_EMIT_SEG    = 4'd7;
  localparam logic [3:0] S_EMIT_SUM    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] src;
  logic [1:0] src_next;
  logic [1:0] leg;
  logic [1:0] leg_next;
  logic [1:0] which;
  logic [1:0] which_next;
  logic       out_valid_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next    = state;
    src_next      = src;
    leg_next      = leg;
    which_next    = which;
    cmd           = '0;
    cmd.src       = src;
    cmd.leg       = leg;
    cmd.which     = which;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK_OLD;
        end
      end
      S_CHECK_OLD: begin
        if (stat.pend_old) begin
          src_next   = SRC_OLD_RUN;
          state_next = S_LOAD;
        end else begin
          state_next = S_CHECK_FLUSH;
        end
      end
      S_CHECK_FLUSH: begin
        if (!stat.pend_last) begin
          state_next = S_IDLE;
        end else if (stat.cur_nonzero) begin
          src_next   = SRC_CUR_RUN;
          state_next = S_LOAD;
        end else begin
          src_next   = SRC_FRAC;
          leg_next   = LEG_FIRST;
          which_next = WHICH_CLAMP;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_next    = S_WAIT;
      end
      S_WAIT: begin
        if (stat.div_done) begin
          cmd.capture = 1'b1;
          if (src != SRC_FRAC) begin
            state_next = S_AFTER_RUN;
          end else if (which == WHICH_LOW) begin
            state_next = S_EMIT_SUM;
          end else begin
            which_next = which + 2'd1;
            state_next = S_LOAD;
          end
        end
      end
      S_AFTER_RUN, S_EMIT_SEG: begin
        if (state == S_AFTER_RUN && stat.seg_ok) begin
          state_next = S_EMIT_SEG;
        end else if (state == S_AFTER_RUN || out_free) begin
          if (state == S_EMIT_SEG) begin
            cmd.out_load  = 1'b1;
            cmd.out_kind  = KIND_SEGMENT;
            cmd.out_final = (src == SRC_OLD_RUN) && !stat.pend_last;
          end
          // the ended run goes first, then the end-of-set work
          if (src == SRC_OLD_RUN) begin
            state_next = S_CHECK_FLUSH;
          end else begin
            src_next   = SRC_FRAC;
            leg_next   = LEG_FIRST;
            which_next = WHICH_CLAMP;
            state_next = S_LOAD;
          end
        end
      end
      S_EMIT_SUM: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = KIND_SUMMARY;
          cmd.out_final = leg == LEG_LAST;
          if (leg == LEG_LAST) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            leg_next   = leg + 2'd1;
            which_next = WHICH_CLAMP;
            state_next = S_LOAD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      src       <= SRC_OLD_RUN;
      leg       <= LEG_FIRST;
      which     <= WHICH_CLAMP;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      src       <= src_next;
      leg       <= leg_next;
      which     <= which_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/clamp_pattern_statistics_unit.sv
`default_nettype none

// Clamp pattern statistics. Each input word is one clamp sample (leg and
// polarity); the block counts clamps per leg and per polarity and tracks
// runs of equal effective polarity. A nonzero run that ends and spans at
// least half a degree gives a segment word with its angle in 1/128 degree;
// the sample flagged end_of_set also flushes the final run and gives three
// per-leg summary words (Q1.16 fractions of sample_total), then the set
// restarts. sample_total is written through cfg_write_en/cfg_write_data;
// the user must write it only while the block is idle, which the block
// itself does not enforce. Every angle and fraction goes through one shared
// divider that makes one quotient bit per cycle, and a stalled output
// holds the block until its word is taken. The next sample is taken while
// the last word still waits at the output.
module clamp_pattern_statistics_unit import cps_pkg::*; #(
  parameter int COUNT_BITS = CPS_COUNT_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [DEN_BITS-1:0] cfg_write_data,
  cps_in_if.sink              in_ch,
  cps_out_if.source           out_ch
);

  cps_cmd_t  cmd;
  cps_stat_t stat;

  cps_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cps_datapath #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .clamp_leg_in      (in_ch.clamp_leg_in),
    .clamp_polarity_in (in_ch.clamp_polarity_in),
    .end_of_set        (in_ch.end_of_set),
    .cmd               (cmd),
    .stat              (stat),
    .result_kind       (out_ch.result_kind),
    .summary_leg       (out_ch.summary_leg),
    .clamp_share       (out_ch.clamp_share),
    .high_fraction     (out_ch.high_fraction),
    .low_fraction      (out_ch.low_fraction),
    .segment_angle     (out_ch.segment_angle),
    .final_result      (out_ch.final_result)
  );

`ifndef NO_ASSERTIONS
  // a word in the output register is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("output word overwritten while stalled");

  // the divider never finishes while a new sample can be taken
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> !in_ch.ready)
    else $error("divider done while idle");

  // an accepted sample always keeps the block busy for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("sample accepted without leaving idle");

  // the set is cleared only together with the last summary word
  a_clear_final: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> (cmd.out_load && cmd.out_final && cmd.out_kind == KIND_SUMMARY))
    else $error("set cleared away from the final summary");
`endif

endmodule

`default_nettype wire
